FILE: rtl/lcrt_pkg.sv
// ----------------------------------------------------------------------------
// lcrt_pkg
// Shared types and constants of the longest consecutive run tracker.
// ----------------------------------------------------------------------------
package lcrt_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int OUT_LEN_W      = 17;

  localparam logic [OUT_LEN_W-1:0] OUT_LEN_MAX = {OUT_LEN_W{1'b1}};

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_INC
  } alu_op_t;

endpackage

FILE: rtl/longest_consecutive_run_tracker_core.sv
// ----------------------------------------------------------------------------
// longest_consecutive_run_tracker_core
// Tracks a set of values and the longest run of consecutive present values.
// ----------------------------------------------------------------------------
// Each value owns one RAM word holding a present bit and a run length that is
// meaningful at run end entries. A request is accepted only while the
// sequencer is idle. An insert of an absent value does three reads (the
// value, its lower and upper neighbor), then three writes (the value and the
// two ends of the joined run), all through the single-write RAM and one
// shared adder. A duplicate insert skips the upper neighbor read and the
// writes. A clear request sweeps all 2^VALUE_BITS RAM entries one entry per
// cycle and then returns a result. After reset the same sweep runs before the
// first request is accepted. The result register lets a new request enter
// while the previous result is still stalled.
module longest_consecutive_run_tracker_core #(
  parameter int VALUE_BITS = lcrt_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic                           req_type,
  input  logic [VALUE_BITS-1:0]          value,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [lcrt_pkg::OUT_LEN_W-1:0] longest_run,
  output logic                           was_duplicate
);

  import lcrt_pkg::*;

  localparam int LEN_W = VALUE_BITS + 1;
  localparam int WORD_W = LEN_W + 1;
  localparam int DEPTH = 1 << VALUE_BITS;
  localparam int CMP_W = (LEN_W > OUT_LEN_W) ? LEN_W : OUT_LEN_W;
  localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_RD_C,
    S_RD_L,
    S_RD_R,
    S_SUM,
    S_TOT,
    S_WR_LO,
    S_WR_HI,
    S_DONE
  } state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] val;
  logic [VALUE_BITS-1:0] nb_addr;
  logic [VALUE_BITS-1:0] lo_addr;
  logic [VALUE_BITS-1:0] hi_addr;
  logic [VALUE_BITS-1:0] cnt;
  logic [LEN_W-1:0]      left;
  logic [LEN_W-1:0]      right;
  logic [LEN_W-1:0]      total;
  logic [LEN_W-1:0]      best;
  logic                  dup;
  logic                  clr_rsp;

  logic                  ram_we;
  logic [VALUE_BITS-1:0] ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic                  ram_re;
  logic [VALUE_BITS-1:0] ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;

  alu_op_t               alu_op;
  logic [LEN_W-1:0]      alu_a;
  logic [LEN_W-1:0]      alu_b;
  logic [LEN_W-1:0]      alu_y;

  logic                  rd_present;
  logic [LEN_W-1:0]      rd_len;
  logic [LEN_W-1:0]      left_now;
  logic [LEN_W-1:0]      right_now;
  logic [CMP_W-1:0]      best_ext;
  logic [OUT_LEN_W-1:0]  best_clip;
  logic                  req_accept;

  assign rd_present = ram_rdata[LEN_W];
  assign rd_len     = ram_rdata[LEN_W-1:0];
  assign left_now   = (val != '0 && rd_present) ? rd_len : '0;
  assign right_now  = (val != VMAX && rd_present) ? rd_len : '0;
  assign best_ext   = CMP_W'(best);
  assign best_clip  = (best_ext > CMP_W'(OUT_LEN_MAX)) ? OUT_LEN_MAX
                                                       : OUT_LEN_W'(best_ext);
  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = val;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = nb_addr;
    alu_op    = ALU_ADD;
    alu_a     = LEN_W'(val);
    alu_b     = '0;
    case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = '0;
      end
      S_RD_C: begin
        ram_re    = 1'b1;
        ram_raddr = val;
        alu_op    = ALU_SUB;
        alu_b     = LEN_W'(1);
      end
      S_RD_L: begin
        ram_re = 1'b1;
        alu_op = ALU_ADD;
        alu_b  = LEN_W'(1);
      end
      S_RD_R: begin
        ram_re = 1'b1;
        alu_op = ALU_SUB;
        alu_b  = left_now;
      end
      S_SUM: begin
        alu_op = ALU_ADD;
        alu_b  = right_now;
      end
      S_TOT: begin
        ram_we    = 1'b1;
        ram_waddr = val;
        ram_wdata = {1'b1, {LEN_W{1'b0}}};
        alu_op    = ALU_INC;
        alu_a     = left;
        alu_b     = right;
      end
      S_WR_LO: begin
        ram_we    = 1'b1;
        ram_waddr = lo_addr;
        ram_wdata = {1'b1, total};
      end
      S_WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_addr;
        ram_wdata = {1'b1, total};
      end
      default: begin
        ram_we = 1'b0;
        ram_re = 1'b0;
      end
    endcase
  end

  lcrt_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lcrt_alu #(
    .W(LEN_W)
  ) u_alu (
    .op(alu_op),
    .a (alu_a),
    .b (alu_b),
    .y (alu_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      cnt       <= '0;
      best      <= LEN_W'(1);
      clr_rsp   <= 1'b0;
      dup       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_accept) begin
            val <= value;
            dup <= 1'b0;
            if (req_type == REQ_CLEAR) begin
              best    <= LEN_W'(1);
              cnt     <= '0;
              clr_rsp <= 1'b1;
              state   <= S_CLR;
            end else begin
              state <= S_RD_C;
            end
          end
        end
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt == VMAX) begin
            state <= clr_rsp ? S_DONE : S_IDLE;
          end
        end
        S_RD_C: begin
          nb_addr <= alu_y[VALUE_BITS-1:0];
          state   <= S_RD_L;
        end
        S_RD_L: begin
          if (rd_present) begin
            dup   <= 1'b1;
            state <= S_DONE;
          end else begin
            nb_addr <= alu_y[VALUE_BITS-1:0];
            state   <= S_RD_R;
          end
        end
        S_RD_R: begin
          left    <= left_now;
          lo_addr <= alu_y[VALUE_BITS-1:0];
          state   <= S_SUM;
        end
        S_SUM: begin
          right   <= right_now;
          hi_addr <= alu_y[VALUE_BITS-1:0];
          state   <= S_TOT;
        end
        S_TOT: begin
          total <= alu_y;
          state <= S_WR_LO;
        end
        S_WR_LO: begin
          if (total > best) begin
            best <= total;
          end
          state <= S_WR_HI;
        end
        S_WR_HI: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid     <= 1'b1;
            longest_run   <= best_clip;
            was_duplicate <= dup;
            clr_rsp       <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_rsp_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> longest_run != '0)
    else $error("result length is zero");

  a_total_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR_LO) |-> (total > left) && (total > right))
    else $error("joined run length wrapped");

  a_best_monotone: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLR && $past(state) != S_CLR) |-> best >= $past(best))
    else $error("best length dropped without clear");

  a_dup_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && dup) |-> $past(state) == S_RD_L || $past(state) == S_DONE)
    else $error("duplicate insert reached the write steps");

endmodule

FILE: rtl/lcrt_ram.sv
// ----------------------------------------------------------------------------
// lcrt_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lcrt_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/lcrt_alu.sv
// ----------------------------------------------------------------------------
// lcrt_alu
// Shared adder/subtractor for neighbor addresses, run ends and run totals.
// ----------------------------------------------------------------------------
module lcrt_alu #(
  parameter int W = 17
) (
  input  lcrt_pkg::alu_op_t op,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      y
);

  import lcrt_pkg::*;

  logic [W-1:0] b_sel;
  logic         cin;

  always_comb begin
    b_sel = b;
    cin   = 1'b0;
    case (op)
      ALU_ADD: begin
        b_sel = b;
        cin   = 1'b0;
      end
      ALU_SUB: begin
        b_sel = ~b;
        cin   = 1'b1;
      end
      ALU_INC: begin
        b_sel = b;
        cin   = 1'b1;
      end
      default: begin
        b_sel = b;
        cin   = 1'b0;
      end
    endcase
  end

  assign y = a + b_sel + W'(cin);

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the longest consecutive run tracker core.
// ----------------------------------------------------------------------------
// A short table of directed requests covers the value range edges, duplicate
// inserts, joins on one or both sides and clears. A dozen windowed random
// phases follow, mixed with noise values and a few clears. Every accepted
// item is run through a local run tracker. Each result is compared with the
// oldest expected result. Both sides idle at random, the receiver holds off
// once for a long stretch, and the sender drains once mid-run.
// ----------------------------------------------------------------------------
module tb;
  import lcrt_pkg::*;

  localparam int VB       = VALUE_BITS_DEF;
  localparam int VCOUNT   = 1 << VB;
  localparam int RAND_N   = 600;
  localparam int DIR_N    = 23;
  localparam int GAP_MAX  = 14;
  localparam int HOLD_LEN = 300;
  localparam int TAIL_LEN = 20;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] len;
    logic                 dup;
  } run_result_t;

  typedef struct packed {
    logic          rt;
    logic [VB-1:0] v;
    logic          typed;
    run_result_t   res;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  logic                 req_type;
  logic [VB-1:0]        value;
  logic                 rsp_valid;
  logic                 rsp_stall;
  logic [OUT_LEN_W-1:0] longest_run;
  logic                 was_duplicate;

  bit          seen_bit [VCOUNT];
  int unsigned span_len [VCOUNT];
  int unsigned best_len;

  run_result_t expected_results [$];

  int fail_count   = 0;
  int items_sent   = 0;
  int clears_sent  = 0;
  int dups_sent    = 0;
  int results_seen = 0;
  bit calm         = 1'b0;
  int rx_hold      = 0;

  dir_row_t dir_rows [DIR_N] = '{
    '{REQ_INSERT, 16'h0000, 1'b1, '{17'd1, 1'b0}},
    '{REQ_INSERT, 16'h0000, 1'b1, '{17'd1, 1'b1}},
    '{REQ_INSERT, 16'hFFFF, 1'b1, '{17'd1, 1'b0}},
    '{REQ_INSERT, 16'hFFFE, 1'b0, '{17'd0, 1'b0}},
    '{REQ_INSERT, 16'h0001, 1'b0, '{17'd0, 1'b0}},
    '{REQ_INSERT, 16'h0003, 1'b0, '{17'd0, 1'b0}},
    '{REQ_INSERT, 16'h0002, 1'b0, '{17'd0, 1'b0}},
    '{REQ_INSERT, 16'hFFFD, 1'b0, '{17'd0, 1'b0}},
    '{REQ_INSERT, 16'h0003, 1'b0, '{17'd0, 1'b0}},
    '{REQ_INSERT, 16'h0001, 1'b0, '{17'd0, 1'b0}},
    '{REQ_INSERT, 16'hAAAA, 1'b0, '{17'd0, 1'b0}},
    '{REQ_INSERT, 16'h5555, 1'b0, '{17'd0, 1'b0}},
    '{REQ_INSERT, 16'h8000, 1'b0, '{17'd0, 1'b0}},
    '{REQ_INSERT, 16'h7FFF, 1'b0, '{17'd0, 1'b0}},
    '{REQ_CLEAR,  16'hFFFF, 1'b1, '{17'd1, 1'b0}},
    '{REQ_INSERT, 16'h0000, 1'b1, '{17'd1, 1'b0}},
    '{REQ_INSERT, 16'hFFFF, 1'b1, '{17'd1, 1'b0}},
    '{REQ_INSERT, 16'h0001, 1'b0, '{17'd0, 1'b0}},
    '{REQ_INSERT, 16'h00FF, 1'b0, '{17'd0, 1'b0}},
    '{REQ_INSERT, 16'h0101, 1'b0, '{17'd0, 1'b0}},
    '{REQ_INSERT, 16'h0100, 1'b0, '{17'd0, 1'b0}},
    '{REQ_CLEAR,  16'h0000, 1'b1, '{17'd1, 1'b0}},
    '{REQ_INSERT, 16'h1234, 1'b1, '{17'd1, 1'b0}}
  };

  longest_consecutive_run_tracker_core #(
    .VALUE_BITS(VB)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .value        (value),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .longest_run  (longest_run),
    .was_duplicate(was_duplicate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic run_result_t track_request(input logic rt, input logic [VB-1:0] v);
    run_result_t r;
    int unsigned lo_len;
    int unsigned hi_len;
    int unsigned total;
    int          vi;
    lo_len = 0;
    hi_len = 0;
    vi     = v;
    if (rt == REQ_CLEAR) begin
      foreach (seen_bit[i]) seen_bit[i] = 1'b0;
      best_len = 1;
      r.len    = OUT_LEN_W'(1);
      r.dup    = 1'b0;
      return r;
    end
    if (seen_bit[vi]) begin
      r.dup = 1'b1;
    end else begin
      if (vi > 0 && seen_bit[vi-1]) lo_len = span_len[vi-1];
      if (vi < VCOUNT - 1 && seen_bit[vi+1]) hi_len = span_len[vi+1];
      total = lo_len + 1 + hi_len;
      span_len[vi - lo_len] = total;
      span_len[vi + hi_len] = total;
      seen_bit[vi] = 1'b1;
      if (total > best_len) best_len = total;
      r.dup = 1'b0;
    end
    r.len = (best_len > OUT_LEN_MAX) ? OUT_LEN_MAX : best_len[OUT_LEN_W-1:0];
    return r;
  endfunction

  task automatic issue(input logic rt, input logic [VB-1:0] v, input logic typed,
                       input run_result_t typed_res);
    int          gap;
    run_result_t pred;
    gap = idle_draw();
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= rt;
    value     <= v;
    do @(posedge clk); while (!(req_valid && !req_stall));
    pred = track_request(rt, v);
    expected_results.insert(expected_results.size(), typed ? typed_res : pred);
    items_sent++;
    if (rt == REQ_CLEAR) clears_sent++;
    else if (pred.dup) dups_sent++;
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int          base;
    int          span;
    logic        rt;
    logic [VB-1:0] v;
    run_result_t none;
    none      = '0;
    rst       = 1'b1;
    req_valid = 1'b0;
    req_type  = REQ_INSERT;
    value     = '0;
    foreach (seen_bit[i]) seen_bit[i] = 1'b0;
    foreach (span_len[i]) span_len[i] = 0;
    best_len = 1;
    base     = 0;
    span     = 15;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      issue(dir_rows[i].rt, dir_rows[i].v, dir_rows[i].typed, dir_rows[i].res);
    end

    for (int i = 0; i < RAND_N; i++) begin
      if (i % 50 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        span = $urandom_range(8, 63);
        case ($urandom_range(0, 3))
          0: base = 0;
          1: base = VCOUNT - 1 - span;
          default: base = $urandom_range(0, VCOUNT - 1 - span);
        endcase
      end
      if (i == 320) rx_hold = HOLD_LEN;
      if (i == 450) begin
        @(negedge clk);
        req_valid <= 1'b0;
        drain();
      end
      if (i % 150 == 149) begin
        rt = REQ_CLEAR;
        v  = VB'($urandom);
      end else if ($urandom_range(0, 99) < 8) begin
        rt = REQ_INSERT;
        v  = VB'($urandom);
      end else begin
        rt = REQ_INSERT;
        v  = VB'(base + $urandom_range(0, span));
      end
      issue(rt, v, 1'b0, none);
    end

    @(negedge clk);
    req_valid <= 1'b0;
    drain();
    repeat (TAIL_LEN) @(posedge clk);
    if (expected_results.size() != 0) begin
      fail_count += expected_results.size();
      $display("tb: %0d expected results never arrived", expected_results.size());
    end
    $display("tb: %0d items sent (%0d clears, %0d duplicate inserts), %0d results checked",
             items_sent, clears_sent, dups_sent, results_seen);
    $display("tb: covered range edges, joins, a long receiver hold-off and a mid-run drain");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int gap;
    rsp_stall = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        gap     = rx_hold;
        rx_hold = 0;
      end else begin
        gap = idle_draw();
      end
      @(negedge clk);
      if (gap > 0) begin
        rsp_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (rsp_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    run_result_t want;
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("tb: result with nothing expected: longest_run=%0d was_duplicate=%0b",
                   longest_run, was_duplicate);
      end else begin
        want = expected_results.pop_front();
        if (longest_run !== want.len || was_duplicate !== want.dup) begin
          fail_count++;
          if (fail_count <= 10)
            $display("tb: mismatch on result %0d: longest_run exp %0d got %0d, %s %0b got %0b",
                     results_seen, want.len, longest_run, "was_duplicate exp",
                     want.dup, was_duplicate);
        end
      end
    end
  end

  initial begin
    #25_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
